FILE: sv/hwpt_pkg.sv
// Shared types, constants and helpers for the head world position transform.
`default_nettype none
package hwpt_pkg;

    localparam int DW = 50;                     // working datapath width
    localparam int BW = 33;                     // multiplier coefficient width
    localparam int PW = DW + BW;                // serial product width

    localparam logic signed [DW-1:0] ONE_Q30     = 50'sd1073741824;
    localparam logic signed [DW-1:0] NEG_ONE_Q30 = -50'sd1073741824;
    localparam logic signed [BW-1:0] PI_Q30      = 33'sh0C90FDAA2;

    localparam logic [2:0] CFG_CABIN_X = 3'd0;
    localparam logic [2:0] CFG_CABIN_Y = 3'd1;
    localparam logic [2:0] CFG_CABIN_Z = 3'd2;
    localparam logic [2:0] CFG_HEAD_X  = 3'd3;
    localparam logic [2:0] CFG_HEAD_Y  = 3'd4;
    localparam logic [2:0] CFG_HEAD_Z  = 3'd5;

    localparam logic [1:0] ANG_HEAD  = 2'd0;
    localparam logic [1:0] ANG_PITCH = 2'd1;
    localparam logic [1:0] ANG_ROLL  = 2'd2;

    typedef enum logic [2:0] {
        KIND_TRUCK = 3'd0,
        KIND_CABIN = 3'd1,
        KIND_HEAD  = 3'd2,
        KIND_SPEED = 3'd3,
        KIND_PAUSE = 3'd4,
        KIND_START = 3'd5,
        KIND_FRAME = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        MDU_MUL_RND = 2'd0,
        MDU_MUL_TRN = 2'd1,
        MDU_DIV     = 2'd2
    } t_mdu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PHASE,
        S_X,
        S_X2,
        S_SMUL,
        S_SDIV,
        S_CMUL,
        S_CDIV,
        S_SFIN,
        S_ROT_GO,
        S_ROT_WAIT,
        S_VEH,
        S_WORLD
    } t_state;

    typedef struct packed {
        logic                   start;
        t_mdu_op                op;
        logic signed [DW-1:0]   a;
        logic signed [BW-1:0]   b;
    } t_mdu_req;

    typedef struct packed {
        logic                   done;
        logic signed [DW-1:0]   res;
    } t_mdu_rsp;

    function automatic logic [8:0] sin_div(input logic [3:0] i);
        case (i)
            4'd0:    return 9'd6;
            4'd1:    return 9'd20;
            4'd2:    return 9'd42;
            4'd3:    return 9'd72;
            4'd4:    return 9'd110;
            4'd5:    return 9'd156;
            4'd6:    return 9'd210;
            4'd7:    return 9'd272;
            default: return 9'd342;
        endcase
    endfunction

    function automatic logic [8:0] cos_div(input logic [3:0] i);
        case (i)
            4'd0:    return 9'd2;
            4'd1:    return 9'd12;
            4'd2:    return 9'd30;
            4'd3:    return 9'd56;
            4'd4:    return 9'd90;
            4'd5:    return 9'd132;
            4'd6:    return 9'd182;
            4'd7:    return 9'd240;
            default: return 9'd306;
        endcase
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [DW-1:0] v);
        if (v > ONE_Q30) begin
            return 32'sh4000_0000;
        end else if (v < NEG_ONE_Q30) begin
            return 32'shC000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if ((&v[47:31]) || !(|v[47:31])) begin
            return v[31:0];
        end else begin
            return v[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [DW:0] v);
        if ((&v[DW:47]) || !(|v[DW:47])) begin
            return v[47:0];
        end else begin
            return v[DW] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        end
    endfunction

endpackage
`default_nettype wire

FILE: sv/hwpt_in_if.sv
// Input channel: telemetry update words.
`default_nettype none
interface hwpt_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic signed [15:0] heading;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [31:0] speed_in;

    modport source (
        output valid, kind, pos_x, pos_y, pos_z, heading, pitch, roll, speed_in,
        input  ready
    );
    modport sink (
        input  valid, kind, pos_x, pos_y, pos_z, heading, pitch, roll, speed_in,
        output ready
    );
endinterface
`default_nettype wire

FILE: sv/hwpt_out_if.sv
// Output channel: head world position words.
`default_nettype none
interface hwpt_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] world_x;
    logic signed [47:0] world_y;
    logic signed [47:0] world_z;
    logic signed [31:0] speed_out;

    modport source (
        output valid, world_x, world_y, world_z, speed_out,
        input  ready
    );
    modport sink (
        input  valid, world_x, world_y, world_z, speed_out,
        output ready
    );
endinterface
`default_nettype wire

FILE: sv/hwpt_mdu.sv
// Bit-serial multiply (Q30 scaled) and divide-by-small-constant unit.
`default_nettype none
module hwpt_mdu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hwpt_pkg::t_mdu_req  i_req,
    output hwpt_pkg::t_mdu_rsp  o_rsp
);
    localparam int DW = hwpt_pkg::DW;
    localparam int BW = hwpt_pkg::BW;
    localparam int PW = hwpt_pkg::PW;

    logic                   r_busy;
    logic                   r_fin;
    logic                   r_done;
    hwpt_pkg::t_mdu_op      r_op;
    logic                   r_neg;
    logic [5:0]             r_cnt;
    logic [PW-1:0]          r_p;
    logic [DW-1:0]          r_ma;
    logic [8:0]             r_rem;
    logic [8:0]             r_d;
    logic signed [DW-1:0]   r_res;

    logic [DW-1:0]          w_ma;
    logic [BW-1:0]          w_mb;
    logic [DW:0]            w_sum;
    logic [9:0]             w_t;
    logic                   w_ge;
    logic [PW-1:0]          w_rnd;
    logic [DW-1:0]          w_q;

    assign w_ma  = i_req.a[DW-1] ? DW'(-i_req.a) : DW'(i_req.a);
    assign w_mb  = i_req.b[BW-1] ? BW'(-i_req.b) : BW'(i_req.b);
    assign w_sum = (DW+1)'(r_p[PW-1:BW]) + (r_p[0] ? {1'b0, r_ma} : '0);
    assign w_t   = {r_rem, r_p[DW-1]};
    assign w_ge  = (w_t >= {1'b0, r_d});
    assign w_rnd = r_p + ((r_op == hwpt_pkg::MDU_MUL_RND) ? (PW'(1) << 29) : '0);
    assign w_q   = (r_op == hwpt_pkg::MDU_DIV) ? r_p[DW-1:0] : w_rnd[30 +: DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_neg  <= i_req.a[DW-1] ^ i_req.b[BW-1];
                r_ma   <= w_ma;
                r_rem  <= '0;
                r_d    <= w_mb[8:0];
                if (i_req.op == hwpt_pkg::MDU_DIV) begin
                    r_p   <= PW'(w_ma);
                    r_cnt <= 6'(DW - 1);
                end else begin
                    r_p   <= {{DW{1'b0}}, w_mb};
                    r_cnt <= 6'(BW - 1);
                end
            end else if (r_busy) begin
                if (r_op == hwpt_pkg::MDU_DIV) begin
                    // restoring long division, one dividend bit per cycle
                    r_rem          <= w_ge ? 9'(w_t - {1'b0, r_d}) : w_t[8:0];
                    r_p[DW-1:0]    <= {r_p[DW-2:0], w_ge};
                end else begin
                    r_p <= {w_sum, r_p[BW-1:1]};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end else if (r_fin) begin
                r_res  <= r_neg ? -$signed(w_q) : $signed(w_q);
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule
`default_nettype wire

FILE: sv/head_world_position_transform.sv
// Top level: head world position from truck, cabin and head placements.
// Update words are registered as they are accepted; a frame end while running
// computes six sine/cosine series and 24 rotation products, all through one
// bit-serial multiply/divide unit.
// One word at a time; the next is taken once the frame result is registered.
// Reset: held state and configuration clear to zero, the block starts paused.
`default_nettype none
module head_world_position_transform #(
    parameter int ANGLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hwpt_in_if.sink     i_in,
    hwpt_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int DW   = hwpt_pkg::DW;
    localparam int BW   = hwpt_pkg::BW;
    localparam int SH_L = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int SH_R = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

    hwpt_pkg::t_state       r_state, n_state;
    hwpt_pkg::t_mdu_req     w_req;
    hwpt_pkg::t_mdu_rsp     w_rsp;

    logic signed [31:0]     r_cfg [6];
    logic signed [47:0]     r_truck_pos [3];
    logic signed [15:0]     r_truck_ang [3];
    logic signed [31:0]     r_cab_off [3];
    logic signed [15:0]     r_cab_ang [3];
    logic signed [31:0]     r_head_off [3];
    logic signed [31:0]     r_speed;
    logic                   r_paused;

    logic [2:0]             r_k;
    logic [3:0]             r_i;
    logic [3:0]             r_j;
    logic                   r_rot;
    logic [1:0]             r_quad;
    logic signed [DW-1:0]   r_x, r_x2, r_ts, r_tc;
    logic signed [DW-1:0]   r_v [3];
    logic signed [DW-1:0]   r_acc, r_x1, r_y1, r_y2, r_z2, r_r0;
    logic signed [31:0]     r_sin [6];
    logic signed [31:0]     r_cos [6];

    logic                   r_ovalid;
    logic signed [47:0]     r_ox, r_oy, r_oz;
    logic signed [31:0]     r_ospeed;

    logic                   w_in_acc;
    logic                   w_out_free;
    logic [15:0]            w_ang;
    logic [39:0]            w_ph_wide;
    logic [ANGLE_BITS-1:0]  w_ph;
    logic signed [DW-1:0]   w_xa;
    logic signed [31:0]     w_s, w_c, w_s_q, w_c_q;
    logic signed [DW-1:0]   w_rot_a;
    logic [1:0]             w_rot_ang;
    logic                   w_rot_sin;
    logic [2:0]             w_tix;
    logic signed [BW-1:0]   w_rot_b;

    hwpt_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == hwpt_pkg::S_IDLE);
    assign w_out_free = !r_ovalid || o_out.ready;

    // angle to phase, quadrant in the top two bits
    assign w_ang     = (r_k < 3'd3) ? r_cab_ang[r_k[1:0]] : r_truck_ang[2'(r_k - 3'd3)];
    assign w_ph_wide = (40'(w_ang) << SH_L) >> SH_R;
    assign w_ph      = w_ph_wide[ANGLE_BITS-1:0];
    assign w_xa      = DW'(w_ph[ANGLE_BITS-3:0]) << (31 - ANGLE_BITS);

    assign w_s = hwpt_pkg::clamp_q30(w_rsp.res);
    assign w_c = hwpt_pkg::clamp_q30(r_tc);

    always_comb begin
        case (r_quad)
            2'd0:    begin w_s_q = w_s;  w_c_q = w_c;  end
            2'd1:    begin w_s_q = w_c;  w_c_q = -w_s; end
            2'd2:    begin w_s_q = -w_s; w_c_q = -w_c; end
            default: begin w_s_q = -w_c; w_c_q = w_s;  end
        endcase
    end

    // rotation product schedule: roll, then pitch, then heading
    always_comb begin
        case (r_j) inside
            4'd0, 4'd2:  w_rot_a = r_v[0];
            4'd1, 4'd3:  w_rot_a = r_v[1];
            4'd4, 4'd6:  w_rot_a = r_y1;
            4'd5, 4'd7:  w_rot_a = r_v[2];
            4'd9, 4'd10: w_rot_a = r_z2;
            default:     w_rot_a = r_x1;
        endcase
        case (r_j) inside
            4'd0, 4'd1, 4'd2, 4'd3: w_rot_ang = hwpt_pkg::ANG_ROLL;
            4'd4, 4'd5, 4'd6, 4'd7: w_rot_ang = hwpt_pkg::ANG_PITCH;
            default:                w_rot_ang = hwpt_pkg::ANG_HEAD;
        endcase
        case (r_j) inside
            4'd1, 4'd2, 4'd5, 4'd6, 4'd9, 4'd11: w_rot_sin = 1'b1;
            default:                             w_rot_sin = 1'b0;
        endcase
    end

    assign w_tix   = {1'b0, w_rot_ang} + (r_rot ? 3'd3 : 3'd0);
    assign w_rot_b = w_rot_sin ? BW'(r_sin[w_tix]) : BW'(r_cos[w_tix]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hwpt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_req.start = 1'b0;
        w_req.op    = hwpt_pkg::MDU_MUL_RND;
        w_req.a     = '0;
        w_req.b     = '0;
        unique case (r_state)
            hwpt_pkg::S_IDLE: begin
                if (w_in_acc && (hwpt_pkg::t_kind'(i_in.kind) == hwpt_pkg::KIND_FRAME)
                        && !r_paused) begin
                    n_state = hwpt_pkg::S_PHASE;
                end
            end
            hwpt_pkg::S_PHASE: begin
                w_req.start = 1'b1;
                w_req.op    = hwpt_pkg::MDU_MUL_TRN;
                w_req.a     = w_xa;
                w_req.b     = hwpt_pkg::PI_Q30;
                n_state     = hwpt_pkg::S_X;
            end
            hwpt_pkg::S_X: begin
                if (w_rsp.done) begin
                    w_req.start = 1'b1;
                    w_req.a     = w_rsp.res;
                    w_req.b     = BW'(w_rsp.res);
                    n_state     = hwpt_pkg::S_X2;
                end
            end
            hwpt_pkg::S_X2: begin
                if (w_rsp.done) begin
                    w_req.start = 1'b1;
                    w_req.a     = w_rsp.res;
                    w_req.b     = BW'(hwpt_pkg::ONE_Q30);
                    n_state     = hwpt_pkg::S_SMUL;
                end
            end
            hwpt_pkg::S_SMUL: begin
                if (w_rsp.done) begin
                    w_req.start = 1'b1;
                    w_req.op    = hwpt_pkg::MDU_DIV;
                    w_req.a     = w_rsp.res;
                    w_req.b     = BW'(hwpt_pkg::sin_div(r_i));
                    n_state     = hwpt_pkg::S_SDIV;
                end
            end
            hwpt_pkg::S_SDIV: begin
                if (w_rsp.done) begin
                    w_req.start = 1'b1;
                    w_req.a     = r_x2;
                    w_req.b     = BW'(r_tc);
                    n_state     = hwpt_pkg::S_CMUL;
                end
            end
            hwpt_pkg::S_CMUL: begin
                if (w_rsp.done) begin
                    w_req.start = 1'b1;
                    w_req.op    = hwpt_pkg::MDU_DIV;
                    w_req.a     = w_rsp.res;
                    w_req.b     = BW'(hwpt_pkg::cos_div(r_i));
                    n_state     = hwpt_pkg::S_CDIV;
                end
            end
            hwpt_pkg::S_CDIV: begin
                if (w_rsp.done) begin
                    w_req.start = 1'b1;
                    w_req.b     = BW'(r_ts);
                    if (r_i == 4'd0) begin
                        w_req.a = r_x;
                        n_state = hwpt_pkg::S_SFIN;
                    end else begin
                        w_req.a = r_x2;
                        n_state = hwpt_pkg::S_SMUL;
                    end
                end
            end
            hwpt_pkg::S_SFIN: begin
                if (w_rsp.done) begin
                    n_state = (r_k == 3'd5) ? hwpt_pkg::S_ROT_GO : hwpt_pkg::S_PHASE;
                end
            end
            hwpt_pkg::S_ROT_GO: begin
                w_req.start = 1'b1;
                w_req.a     = w_rot_a;
                w_req.b     = w_rot_b;
                n_state     = hwpt_pkg::S_ROT_WAIT;
            end
            hwpt_pkg::S_ROT_WAIT: begin
                if (w_rsp.done) begin
                    if (r_j == 4'd11) begin
                        n_state = r_rot ? hwpt_pkg::S_WORLD : hwpt_pkg::S_VEH;
                    end else begin
                        n_state = hwpt_pkg::S_ROT_GO;
                    end
                end
            end
            hwpt_pkg::S_VEH: begin
                n_state = hwpt_pkg::S_ROT_GO;
            end
            hwpt_pkg::S_WORLD: begin
                if (w_out_free) begin
                    n_state = hwpt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hwpt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 6; n++) begin
                r_cfg[n] <= '0;
            end
            for (int n = 0; n < 3; n++) begin
                r_truck_pos[n] <= '0;
                r_truck_ang[n] <= '0;
                r_cab_off[n]   <= '0;
                r_cab_ang[n]   <= '0;
                r_head_off[n]  <= '0;
            end
            r_speed  <= '0;
            r_paused <= 1'b1;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_rot    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hwpt_pkg::CFG_CABIN_X: r_cfg[0] <= i_cfg_data;
                    hwpt_pkg::CFG_CABIN_Y: r_cfg[1] <= i_cfg_data;
                    hwpt_pkg::CFG_CABIN_Z: r_cfg[2] <= i_cfg_data;
                    hwpt_pkg::CFG_HEAD_X:  r_cfg[3] <= i_cfg_data;
                    hwpt_pkg::CFG_HEAD_Y:  r_cfg[4] <= i_cfg_data;
                    hwpt_pkg::CFG_HEAD_Z:  r_cfg[5] <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                unique case (hwpt_pkg::t_kind'(i_in.kind))
                    hwpt_pkg::KIND_TRUCK: begin
                        r_truck_pos[0] <= i_in.pos_x;
                        r_truck_pos[1] <= i_in.pos_y;
                        r_truck_pos[2] <= i_in.pos_z;
                        r_truck_ang[0] <= i_in.heading;
                        r_truck_ang[1] <= i_in.pitch;
                        r_truck_ang[2] <= i_in.roll;
                    end
                    hwpt_pkg::KIND_CABIN: begin
                        r_cab_off[0] <= hwpt_pkg::sat32(i_in.pos_x);
                        r_cab_off[1] <= hwpt_pkg::sat32(i_in.pos_y);
                        r_cab_off[2] <= hwpt_pkg::sat32(i_in.pos_z);
                        r_cab_ang[0] <= i_in.heading;
                        r_cab_ang[1] <= i_in.pitch;
                        r_cab_ang[2] <= i_in.roll;
                    end
                    hwpt_pkg::KIND_HEAD: begin
                        r_head_off[0] <= hwpt_pkg::sat32(i_in.pos_x);
                        r_head_off[1] <= hwpt_pkg::sat32(i_in.pos_y);
                        r_head_off[2] <= hwpt_pkg::sat32(i_in.pos_z);
                    end
                    hwpt_pkg::KIND_SPEED: r_speed  <= i_in.speed_in;
                    hwpt_pkg::KIND_PAUSE: r_paused <= 1'b1;
                    hwpt_pkg::KIND_START: r_paused <= 1'b0;
                    hwpt_pkg::KIND_FRAME: begin
                        // head position in cabin space
                        for (int n = 0; n < 3; n++) begin
                            r_v[n] <= DW'(r_cfg[3 + n]) + DW'(r_head_off[n]);
                        end
                        r_k <= '0;
                    end
                    default: ;
                endcase
            end

            // a new word loaded in S_WORLD takes the place of the one leaving
            if (r_ovalid && o_out.ready && (r_state != hwpt_pkg::S_WORLD)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                hwpt_pkg::S_PHASE: r_quad <= w_ph[ANGLE_BITS-1:ANGLE_BITS-2];
                hwpt_pkg::S_X: begin
                    if (w_rsp.done) r_x <= w_rsp.res;
                end
                hwpt_pkg::S_X2: begin
                    if (w_rsp.done) begin
                        r_x2 <= w_rsp.res;
                        r_ts <= hwpt_pkg::ONE_Q30;
                        r_tc <= hwpt_pkg::ONE_Q30;
                        r_i  <= 4'd8;
                    end
                end
                hwpt_pkg::S_SDIV: begin
                    if (w_rsp.done) r_ts <= hwpt_pkg::ONE_Q30 - w_rsp.res;
                end
                hwpt_pkg::S_CDIV: begin
                    if (w_rsp.done) begin
                        r_tc <= hwpt_pkg::ONE_Q30 - w_rsp.res;
                        if (r_i != 4'd0) r_i <= r_i - 4'd1;
                    end
                end
                hwpt_pkg::S_SFIN: begin
                    if (w_rsp.done) begin
                        r_sin[r_k] <= w_s_q;
                        r_cos[r_k] <= w_c_q;
                        if (r_k == 3'd5) begin
                            r_j   <= '0;
                            r_rot <= 1'b0;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                end
                hwpt_pkg::S_ROT_WAIT: begin
                    if (w_rsp.done) begin
                        case (r_j)
                            4'd1:  r_x1 <= r_acc - w_rsp.res;
                            4'd3:  r_y1 <= r_acc + w_rsp.res;
                            4'd5:  r_y2 <= r_acc - w_rsp.res;
                            4'd7:  r_z2 <= r_acc + w_rsp.res;
                            4'd9:  r_r0 <= r_acc + w_rsp.res;
                            4'd11: begin
                                r_v[0] <= r_r0;
                                r_v[1] <= r_y2;
                                r_v[2] <= r_acc - w_rsp.res;
                            end
                            default: r_acc <= w_rsp.res;
                        endcase
                        if (r_j != 4'd11) r_j <= r_j + 4'd1;
                    end
                end
                hwpt_pkg::S_VEH: begin
                    for (int n = 0; n < 3; n++) begin
                        r_v[n] <= r_v[n] + DW'(r_cfg[n]) + DW'(r_cab_off[n]);
                    end
                    r_rot <= 1'b1;
                    r_j   <= '0;
                end
                hwpt_pkg::S_WORLD: begin
                    if (w_out_free) begin
                        r_ox     <= hwpt_pkg::sat48((DW+1)'(r_truck_pos[0]) + (DW+1)'(r_v[0]));
                        r_oy     <= hwpt_pkg::sat48((DW+1)'(r_truck_pos[1]) + (DW+1)'(r_v[1]));
                        r_oz     <= hwpt_pkg::sat48((DW+1)'(r_truck_pos[2]) + (DW+1)'(r_v[2]));
                        r_ospeed <= r_speed;
                        r_ovalid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.world_x   = r_ox;
    assign o_out.world_y   = r_oy;
    assign o_out.world_z   = r_oz;
    assign o_out.speed_out = r_ospeed;

endmodule
`default_nettype wire

FILE: test/head_world_position_transform_tb.sv
// Testbench for head_world_position_transform: random telemetry words against a predictor.
`timescale 1ns / 100ps
module head_world_position_transform_tb;

    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;
    localparam longint     Q30_ONE     = 64'sd1073741824;
    localparam longint     HI48        = (64'sd1 <<< 47) - 1;
    localparam longint     LO48        = -(64'sd1 <<< 47);
    localparam longint     HI32        = 64'sd2147483647;
    localparam longint     LO32        = -64'sd2147483648;
    localparam int         CYCLE_LIMIT = 80000000;

    typedef struct {
        logic [2:0]         kind;
        logic signed [47:0] px, py, pz;
        logic signed [15:0] hd, pt, rl;
        logic signed [31:0] spd;
    } telem_word_t;

    typedef struct {
        logic signed [47:0] wx, wy, wz;
        logic signed [31:0] spd;
    } world_pos_t;

    class world_pos_predictor;
        longint     cfg_reg[6];
        longint     truck_pos[3], cab_off[3], head_off[3];
        bit [15:0]  truck_ang[3], cab_ang[3];
        longint     speed_held;
        bit         paused;
        world_pos_t expected_pos[$];
        int         mismatches;
        longint     sin_terms[9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};
        longint     cos_terms[9] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};

        function new();
            foreach (cfg_reg[i]) cfg_reg[i] = 0;
            foreach (truck_pos[i]) begin
                truck_pos[i] = 0; cab_off[i] = 0; head_off[i] = 0;
                truck_ang[i] = 0; cab_ang[i] = 0;
            end
            speed_held = 0;
            paused = 1;
            mismatches = 0;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // v * k / 2^30, nearest, ties away from zero
        function longint mulq(longint v, longint k);
            bit neg;
            bit [63:0] mv, mk, hi, lo, r;
            neg = (v < 0) != (k < 0);
            mv = v < 0 ? 64'd0 - 64'(v) : 64'(v);
            mk = k < 0 ? 64'd0 - 64'(k) : 64'(k);
            hi = mv >> 32;
            lo = mv & 64'hFFFF_FFFF;
            r = ((hi * mk) << 2) + ((lo * mk + (64'd1 << 29)) >> 30);
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function void sin_cos(bit [15:0] a, output longint so, output longint co);
            bit [63:0] rem;
            longint x, x2, ts, tc, s, c;
            rem = 64'(a[13:0]);
            x = longint'((rem * 64'hC90F_DAA2) >> 15);
            x2 = mulq(x, x);
            ts = Q30_ONE;
            tc = Q30_ONE;
            for (int i = 8; i >= 0; i--) begin
                ts = Q30_ONE - mulq(x2, ts) / sin_terms[i];
                tc = Q30_ONE - mulq(x2, tc) / cos_terms[i];
            end
            s = clip(mulq(x, ts), -Q30_ONE, Q30_ONE);
            c = clip(tc, -Q30_ONE, Q30_ONE);
            case (a[15:14])
                2'd0: begin so = s; co = c; end
                2'd1: begin so = c; co = -s; end
                2'd2: begin so = -s; co = -c; end
                default: begin so = -c; co = s; end
            endcase
        endfunction

        // roll about Z, pitch about X, heading about Y
        function void rotate(bit [15:0] ang[3], longint v[3], output longint r[3]);
            longint sh, ch, sp, cp, sr, cr, x1, y1, y2, z2;
            sin_cos(ang[0], sh, ch);
            sin_cos(ang[1], sp, cp);
            sin_cos(ang[2], sr, cr);
            x1 = mulq(v[0], cr) - mulq(v[1], sr);
            y1 = mulq(v[0], sr) + mulq(v[1], cr);
            y2 = mulq(y1, cp) - mulq(v[2], sp);
            z2 = mulq(y1, sp) + mulq(v[2], cp);
            r[0] = mulq(x1, ch) + mulq(z2, sh);
            r[1] = y2;
            r[2] = mulq(z2, ch) - mulq(x1, sh);
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            if (idx < 6) cfg_reg[idx] = longint'($signed(data));
        endfunction

        function void note_word(telem_word_t w);
            longint p[3], head[3], veh[3], rv[3], rw[3];
            bit [15:0] o[3];
            world_pos_t res;
            p = '{longint'(w.px), longint'(w.py), longint'(w.pz)};
            o = '{w.hd, w.pt, w.rl};
            case (w.kind)
                hwpt_pkg::KIND_TRUCK: begin truck_pos = p; truck_ang = o; end
                hwpt_pkg::KIND_CABIN: begin
                    foreach (p[i]) cab_off[i] = clip(p[i], LO32, HI32);
                    cab_ang = o;
                end
                hwpt_pkg::KIND_HEAD: foreach (p[i]) head_off[i] = clip(p[i], LO32, HI32);
                hwpt_pkg::KIND_SPEED: speed_held = longint'(w.spd);
                hwpt_pkg::KIND_PAUSE: paused = 1;
                hwpt_pkg::KIND_START: paused = 0;
                hwpt_pkg::KIND_FRAME: if (!paused) begin
                    foreach (head[i]) head[i] = cfg_reg[3 + i] + head_off[i];
                    rotate(cab_ang, head, rv);
                    foreach (veh[i]) veh[i] = cfg_reg[i] + cab_off[i] + rv[i];
                    rotate(truck_ang, veh, rw);
                    res.wx = 48'(clip(truck_pos[0] + rw[0], LO48, HI48));
                    res.wy = 48'(clip(truck_pos[1] + rw[1], LO48, HI48));
                    res.wz = 48'(clip(truck_pos[2] + rw[2], LO48, HI48));
                    res.spd = 32'(speed_held);
                    expected_pos.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_pos(world_pos_t got);
            world_pos_t exp_pos;
            if (expected_pos.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: x %0d y %0d z %0d speed %0d",
                             got.wx, got.wy, got.wz, got.spd);
                return;
            end
            exp_pos = expected_pos.pop_front();
            if (got.wx !== exp_pos.wx || got.wy !== exp_pos.wy ||
                got.wz !== exp_pos.wz || got.spd !== exp_pos.spd) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp x %0d y %0d z %0d speed %0d, got x %0d y %0d z %0d speed %0d",
                             exp_pos.wx, exp_pos.wy, exp_pos.wz, exp_pos.spd,
                             got.wx, got.wy, got.wz, got.spd);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    hwpt_in_if  in_ch();
    hwpt_out_if out_ch();

    head_world_position_transform DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    world_pos_predictor pred;
    int  cycle_cnt;
    bit  in_burst, out_burst;
    int  hold_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("head_world_position_transform verification failed");
            $finish;
        end
    end

    // accepted words and results, sampled at the rising edge
    always @(posedge i_clk) begin
        telem_word_t w;
        world_pos_t r;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            w.kind = in_ch.kind;
            w.px = in_ch.pos_x; w.py = in_ch.pos_y; w.pz = in_ch.pos_z;
            w.hd = in_ch.heading; w.pt = in_ch.pitch; w.rl = in_ch.roll;
            w.spd = in_ch.speed_in;
            pred.note_word(w);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            r.wx = out_ch.world_x; r.wy = out_ch.world_y; r.wz = out_ch.world_z;
            r.spd = out_ch.speed_out;
            pred.check_pos(r);
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                out_ch.ready = 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            gap = out_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic send_word(telem_word_t w);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.kind = w.kind;
        in_ch.pos_x = w.px; in_ch.pos_y = w.py; in_ch.pos_z = w.pz;
        in_ch.heading = w.hd; in_ch.pitch = w.pt; in_ch.roll = w.rl;
        in_ch.speed_in = w.spd;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pred.expected_pos.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        pred.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_bases(int mode);
        logic [31:0] v;
        for (int i = 0; i < 6; i++) begin
            case (mode)
                0: v = 32'h7FFF_FFFF;
                1: v = 32'h8000_0000;
                2: v = $urandom_range(0, 1) ? 32'($signed($urandom_range(0, 262143)) - 131072)
                                            : $urandom;
                default: v = $urandom;
            endcase
            write_reg(3'(i), v);
        end
    endtask

    function automatic logic signed [47:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 48'({$urandom, $urandom});
            1: return $urandom_range(0, 1) ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000;
            2: return 48'($signed($urandom));
            default: return 48'($signed($urandom_range(0, 67108863)) - 33554432);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_ang();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom_range(0, 3) << 14);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic telem_word_t make_word(logic [2:0] kind);
        telem_word_t w;
        w.kind = kind;
        w.px = rand_pos(); w.py = rand_pos(); w.pz = rand_pos();
        w.hd = rand_ang(); w.pt = rand_ang(); w.rl = rand_ang();
        w.spd = $urandom;
        return w;
    endfunction

    function automatic telem_word_t fixed_word(logic [2:0] kind, logic signed [47:0] p,
                                               logic signed [15:0] a, logic signed [31:0] s);
        telem_word_t w;
        w = make_word(kind);
        w.px = p; w.py = p; w.pz = p;
        w.hd = a; w.pt = a; w.rl = a;
        w.spd = s;
        return w;
    endfunction

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return hwpt_pkg::KIND_FRAME;
        if (r < 25) return hwpt_pkg::KIND_TRUCK;
        if (r < 45) return hwpt_pkg::KIND_CABIN;
        if (r < 63) return hwpt_pkg::KIND_HEAD;
        if (r < 78) return hwpt_pkg::KIND_SPEED;
        if (r < 81) return hwpt_pkg::KIND_PAUSE;
        if (r < 96) return hwpt_pkg::KIND_START;
        return KIND_UNUSED;
    endfunction

    task automatic random_phase(int n_words);
        for (int i = 0; i < n_words; i++) begin
            if (i % 50 == 0) begin
                in_burst = ($urandom_range(0, 3) == 0);
                out_burst = ($urandom_range(0, 3) == 0);
            end
            send_word(make_word(pick_kind()));
        end
        in_burst = 0;
        out_burst = 0;
    endtask

    initial begin
        pred = new();
        cycle_cnt = 0;
        hold_cycles = 0;
        in_burst = 0;
        out_burst = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = '0;
        in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
        in_ch.heading = '0; in_ch.pitch = '0; in_ch.roll = '0;
        in_ch.speed_in = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // out-of-range indexes must be dropped
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        write_bases(3);

        // directed: paused frame, unknown kind, extremes, narrowing, saturation
        send_word(make_word(hwpt_pkg::KIND_FRAME));
        send_word(make_word(KIND_UNUSED));
        send_word(make_word(hwpt_pkg::KIND_START));
        send_word(make_word(hwpt_pkg::KIND_FRAME));
        send_word(fixed_word(hwpt_pkg::KIND_TRUCK, 48'sh7FFF_FFFF_FFFF, 16'sh0000, 32'sh0));
        send_word(fixed_word(hwpt_pkg::KIND_CABIN, 48'sh0000_7FFF_FFFF, 16'sh0000, 32'sh0));
        send_word(fixed_word(hwpt_pkg::KIND_HEAD, 48'sh0100_0000_0000, 16'sh7FFF, 32'sh0));
        send_word(fixed_word(hwpt_pkg::KIND_SPEED, 48'sh0, 16'sh0, 32'sh7FFF_FFFF));
        send_word(make_word(hwpt_pkg::KIND_FRAME));
        send_word(fixed_word(hwpt_pkg::KIND_TRUCK, 48'sh8000_0000_0000, 16'sh8000, 32'sh0));
        send_word(fixed_word(hwpt_pkg::KIND_CABIN, 48'shFF00_0000_0000, 16'sh8000, 32'sh0));
        send_word(fixed_word(hwpt_pkg::KIND_HEAD, 48'sh8000_0000_0000, 16'sh4000, 32'sh0));
        send_word(fixed_word(hwpt_pkg::KIND_SPEED, 48'sh0, 16'sh0, 32'sh8000_0000));
        send_word(make_word(hwpt_pkg::KIND_FRAME));
        send_word(fixed_word(hwpt_pkg::KIND_CABIN, 48'sh7FFF_FFFF_FFFF, 16'sh7FFF, 32'sh0));
        send_word(fixed_word(hwpt_pkg::KIND_TRUCK, 48'sh0000_1234_5678, 16'shC000, 32'sh0));
        send_word(make_word(hwpt_pkg::KIND_FRAME));
        send_word(make_word(hwpt_pkg::KIND_PAUSE));
        send_word(make_word(hwpt_pkg::KIND_FRAME));
        send_word(make_word(hwpt_pkg::KIND_START));
        send_word(make_word(hwpt_pkg::KIND_FRAME));
        drain();

        write_bases(0);
        send_word(make_word(hwpt_pkg::KIND_START));
        hold_cycles = 40000;     // result side stalls, input backs up behind it
        random_phase(370);
        drain();

        write_bases(1);
        send_word(make_word(hwpt_pkg::KIND_START));
        random_phase(370);
        drain();

        for (int i = 0; i < 6; i++) write_reg(3'(i), 32'h0);
        send_word(make_word(hwpt_pkg::KIND_START));
        random_phase(370);
        drain();

        write_bases(2);
        send_word(make_word(hwpt_pkg::KIND_START));
        random_phase(370);
        drain();
        repeat (200) @(posedge i_clk);

        if (pred.mismatches == 0 && pred.expected_pos.size() == 0) begin
            $display("head_world_position_transform verification clean");
        end else begin
            $display("head_world_position_transform verification failed");
        end
        $finish;
    end
endmodule
